[hw/rtl/hpfk_pkg.sv]
// Shared constants and the arctangent table for the head pose pipeline.
// No dependencies; imported by every module of the block.
package hpfk_pkg;

    localparam int QFRAC   = 16;
    localparam int ZW      = 26;
    localparam int OUT_W   = 14;
    localparam int LIMIT_W = 13;
    localparam int KINV_W  = 28;

    localparam logic [KINV_W-1:0]  KINV_Q28          = 28'd163008219;
    localparam logic [LIMIT_W-1:0] YAW_LIMIT_RESET   = 13'd3840;
    localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RESET = 13'd2560;
    localparam logic signed [ZW-1:0] ROLL_MAX_Q16    = 26'sd5898240;

    localparam logic REG_YAW_LIMIT   = 1'b0;
    localparam logic REG_PITCH_LIMIT = 1'b1;

    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = 26'sd2949120;
            1:  r = 26'sd1740967;
            2:  r = 26'sd919879;
            3:  r = 26'sd466945;
            4:  r = 26'sd234379;
            5:  r = 26'sd117304;
            6:  r = 26'sd58666;
            7:  r = 26'sd29335;
            8:  r = 26'sd14668;
            9:  r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/hpfk_cordic_cell.sv]
// One vectoring CORDIC micro-rotation for one or more lanes, with a side payload.
// Depends on hpfk_pkg for the arctangent table.
module hpfk_cordic_cell #(
    parameter int W      = 33,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1,
    parameter int STAGE  = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [LANES-1:0][W-1:0]              x_in,
    input  logic [LANES-1:0][W-1:0]              y_in,
    input  logic [LANES-1:0][hpfk_pkg::ZW-1:0]   z_in,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [LANES-1:0][W-1:0]              x_out,
    output logic [LANES-1:0][W-1:0]              y_out,
    output logic [LANES-1:0][hpfk_pkg::ZW-1:0]   z_out,
    output logic [SIDE_W-1:0]                    side_out
);
    import hpfk_pkg::*;

    logic                        valid_reg;
    logic [LANES-1:0][W-1:0]     x_reg, x_next;
    logic [LANES-1:0][W-1:0]     y_reg, y_next;
    logic [LANES-1:0][ZW-1:0]    z_reg, z_next;
    logic [SIDE_W-1:0]           side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (!y_in[l][W-1])
            begin
                x_next[l] = W'($signed(x_in[l]) + ($signed(y_in[l]) >>> STAGE));
                y_next[l] = W'($signed(y_in[l]) - ($signed(x_in[l]) >>> STAGE));
                z_next[l] = ZW'($signed(z_in[l]) + atan_q16(STAGE));
            end
            else
            begin
                x_next[l] = W'($signed(x_in[l]) - ($signed(y_in[l]) >>> STAGE));
                y_next[l] = W'($signed(y_in[l]) + ($signed(x_in[l]) >>> STAGE));
                z_next[l] = ZW'($signed(z_in[l]) - atan_q16(STAGE));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

[hw/rtl/hpfk_scale.sv]
// Two-stage multiply of the roll magnitude by 1/K, giving the doubled eye distance.
// Depends on hpfk_pkg for the reciprocal gain constant.
module hpfk_scale #(
    parameter int W      = 33,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [W-1:0]      x_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [W-1:0]      d2_out,
    output logic [SIDE_W-1:0] side_out
);
    import hpfk_pkg::*;

    localparam int HW  = W - 16;
    localparam int PLW = 16 + KINV_W;
    localparam int PHW = HW + KINV_W;
    localparam int SW  = PHW + 17;

    logic              v1_reg, v2_reg;
    logic              r1, r2;
    logic [PLW-1:0]    pl_reg;
    logic [PHW-1:0]    ph_reg;
    logic [SIDE_W-1:0] s1_reg, s2_reg;
    logic [W-1:0]      d2_reg;
    logic [SW-1:0]     sum;

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign sum = {1'b0, ph_reg, 16'b0} + SW'(pl_reg) + (SW'(1) << 26);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            pl_reg <= PLW'(x_in[15:0]) * PLW'(KINV_Q28);
            ph_reg <= PHW'(x_in[W-1:16]) * PHW'(KINV_Q28);
            s1_reg <= side_in;
        end
        if (r2 && v1_reg)
        begin
            d2_reg <= sum[W+26:27];
            s2_reg <= s1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign d2_out    = d2_reg;
    assign side_out  = s2_reg;

endmodule

[hw/rtl/head_pose_from_face_keypoints_core.sv]
// Head pose from nose and eye keypoints: top level with roll chain, scale and yaw/pitch chain.
// Throughput 1 per cycle while out_stall is low; the result is registered through
// the two CORDIC cell chains, the two multiply stages and the output register.
// Reset clears all valid flags and loads yaw_limit 3840 and pitch_limit 2560.
// Depends on hpfk_pkg, hpfk_cordic_cell and hpfk_scale.
module head_pose_from_face_keypoints_core #(
    parameter int COORD_BITS      = 12,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [hpfk_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        nose_x,
    input  logic signed [COORD_BITS-1:0]        nose_y,
    input  logic signed [COORD_BITS-1:0]        left_eye_x,
    input  logic signed [COORD_BITS-1:0]        left_eye_y,
    input  logic signed [COORD_BITS-1:0]        right_eye_x,
    input  logic signed [COORD_BITS-1:0]        right_eye_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pose_valid,
    output logic signed [hpfk_pkg::OUT_W-1:0]   yaw_angle,
    output logic signed [hpfk_pkg::OUT_W-1:0]   pitch_angle,
    output logic signed [hpfk_pkg::OUT_W-1:0]   roll_angle
);
    import hpfk_pkg::*;

    localparam int W     = COORD_BITS + 21;
    localparam int NW    = COORD_BITS + 3;
    localparam int DW    = COORD_BITS + 1;
    localparam int SH    = QFRAC - ANGLE_FRAC_BITS;
    localparam int RSW   = 1 + 2 * NW;
    localparam int SSW   = RSW + ZW;
    localparam int YSW   = 1 + ZW;
    localparam int N     = CORDIC_STAGES;

    logic [LIMIT_W-1:0] yaw_limit_reg, pitch_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_limit_reg   <= YAW_LIMIT_RESET;
            pitch_limit_reg <= PITCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_YAW_LIMIT:   yaw_limit_reg   <= cfg_data;
                REG_PITCH_LIMIT: pitch_limit_reg <= cfg_data;
                default:         yaw_limit_reg   <= yaw_limit_reg;
            endcase
        end
    end

    // front end: validity, fold eye vector into the right half plane
    logic              pv;
    logic signed [DW-1:0] ddx, ddy, ax, ay;
    logic signed [NW-1:0] numx, numy;

    assign pv = (nose_x > 0) && (nose_y > 0) && (left_eye_x > 0) && (left_eye_y > 0)
             && (right_eye_x > 0) && (right_eye_y > 0)
             && ((left_eye_x != right_eye_x) || (left_eye_y != right_eye_y));
    assign ddx  = DW'(right_eye_x) - DW'(left_eye_x);
    assign ddy  = DW'(right_eye_y) - DW'(left_eye_y);
    assign ax   = ddx[DW-1] ? -ddx : ddx;
    assign ay   = ddx[DW-1] ? -ddy : ddy;
    assign numx = (NW'(nose_x) <<< 1) - NW'(left_eye_x) - NW'(right_eye_x);
    assign numy = (NW'(nose_y) <<< 1) - NW'(left_eye_y) - NW'(right_eye_y);

    // roll chain
    logic [N:0]                rv, rr;
    logic [N:0][W-1:0]         rxv, ryv;
    logic [N:0][ZW-1:0]        rzv;
    logic [N:0][RSW-1:0]       rsv;

    assign rv[0]  = in_valid;
    assign rxv[0] = W'(ax) << QFRAC;
    assign ryv[0] = W'(ay) << QFRAC;
    assign rzv[0] = '0;
    assign rsv[0] = {pv, numy, numx};
    assign in_stall = !rr[0];

    for (genvar g = 0; g < N; g++)
    begin : g_roll
        hpfk_cordic_cell #(.W(W), .LANES(1), .SIDE_W(RSW), .STAGE(g)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(rv[g]), .in_ready(rr[g]),
            .x_in(rxv[g]), .y_in(ryv[g]), .z_in(rzv[g]), .side_in(rsv[g]),
            .out_valid(rv[g+1]), .out_ready(rr[g+1]),
            .x_out(rxv[g+1]), .y_out(ryv[g+1]), .z_out(rzv[g+1]), .side_out(rsv[g+1])
        );
    end

    // scale to doubled eye distance
    logic [W-1:0]   d2;
    logic [SSW-1:0] ss;
    logic           sv;
    logic [N:0]     yv, yr;

    hpfk_scale #(.W(W), .SIDE_W(SSW)) u_scale (
        .clk(clk), .rst_n(rst_n),
        .in_valid(rv[N]), .in_ready(rr[N]),
        .x_in(rxv[N]), .side_in({rsv[N], rzv[N]}),
        .out_valid(sv), .out_ready(yr[0]),
        .d2_out(d2), .side_out(ss)
    );

    // yaw (lane 0) and pitch (lane 1) chain
    logic [N:0][1:0][W-1:0]  yxv, yyv;
    logic [N:0][1:0][ZW-1:0] yzv;
    logic [N:0][YSW-1:0]     ysv;
    logic signed [NW-1:0]    s_numx, s_numy;

    assign s_numx = ss[ZW +: NW];
    assign s_numy = ss[ZW+NW +: NW];
    assign yv[0]  = sv;
    assign yxv[0] = {d2, d2};
    assign yyv[0] = {W'(s_numy) << QFRAC, W'(s_numx) << QFRAC};
    assign yzv[0] = '0;
    assign ysv[0] = {ss[SSW-1], ss[ZW-1:0]};

    for (genvar g = 0; g < N; g++)
    begin : g_yp
        hpfk_cordic_cell #(.W(W), .LANES(2), .SIDE_W(YSW), .STAGE(g)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(yv[g]), .in_ready(yr[g]),
            .x_in(yxv[g]), .y_in(yyv[g]), .z_in(yzv[g]), .side_in(ysv[g]),
            .out_valid(yv[g+1]), .out_ready(yr[g+1]),
            .x_out(yxv[g+1]), .y_out(yyv[g+1]), .z_out(yzv[g+1]), .side_out(ysv[g+1])
        );
    end

    // round, clamp and hold the result
    logic signed [ZW:0]   yaw_r, pitch_r, roll_r, roll_c, yaw_c, pitch_c;
    logic signed [ZW:0]   ylim, plim, half;
    logic signed [ZW-1:0] roll_z;
    logic                 ov_reg, pv_reg;
    logic [OUT_W-1:0]     yaw_reg, pitch_reg, roll_reg;

    assign half   = (ZW+1)'(1) <<< (SH - 1);
    assign roll_z = ysv[N][ZW-1:0];
    assign ylim   = (ZW+1)'(yaw_limit_reg);
    assign plim   = (ZW+1)'(pitch_limit_reg);

    always_comb
    begin
        if (roll_z > ROLL_MAX_Q16)
            roll_c = (ZW+1)'(ROLL_MAX_Q16);
        else if (roll_z < -ROLL_MAX_Q16)
            roll_c = -(ZW+1)'(ROLL_MAX_Q16);
        else
            roll_c = (ZW+1)'(roll_z);
        roll_r  = (roll_c + half) >>> SH;
        yaw_r   = ((ZW+1)'($signed(yzv[N][0])) + half) >>> SH;
        pitch_r = ((ZW+1)'($signed(yzv[N][1])) + half) >>> SH;
        if (yaw_r > ylim)
            yaw_c = ylim;
        else if (yaw_r < -ylim)
            yaw_c = -ylim;
        else
            yaw_c = yaw_r;
        if (pitch_r > plim)
            pitch_c = plim;
        else if (pitch_r < -plim)
            pitch_c = -plim;
        else
            pitch_c = pitch_r;
    end

    assign yr[N] = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (yr[N])
            ov_reg <= yv[N];
    end

    always_ff @(posedge clk)
    begin
        if (yr[N] && yv[N])
        begin
            pv_reg    <= ysv[N][YSW-1];
            yaw_reg   <= ysv[N][YSW-1] ? yaw_c[OUT_W-1:0]   : '0;
            pitch_reg <= ysv[N][YSW-1] ? pitch_c[OUT_W-1:0] : '0;
            roll_reg  <= ysv[N][YSW-1] ? roll_r[OUT_W-1:0]  : '0;
        end
    end

    assign out_valid   = ov_reg;
    assign pose_valid  = pv_reg;
    assign yaw_angle   = yaw_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;

endmodule

[sim/tb_head_pose_from_face_keypoints_core.sv]
// Testbench for head_pose_from_face_keypoints_core: directed and random faces against a
// bit-accurate CORDIC pose predictor, with random input gaps and random output stalls.
// Depends on hpfk_pkg and the core RTL.
module tb_head_pose_from_face_keypoints_core;
    import hpfk_pkg::*;

    localparam int CB = 12;
    localparam int NSTG = 16;
    localparam int AFB = 6;

    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] yaw;
        logic [OUT_W-1:0] pitch;
        logic [OUT_W-1:0] roll;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = REG_YAW_LIMIT;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] nose_x = '0, nose_y = '0, left_eye_x = '0, left_eye_y = '0;
    logic signed [CB-1:0] right_eye_x = '0, right_eye_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic pose_valid;
    logic signed [OUT_W-1:0] yaw_angle, pitch_angle, roll_angle;

    longint yaw_lim = 3840;
    longint pitch_lim = 2560;
    pose_t pending_poses[$];
    int mismatches = 0;
    bit quiet = 1'b0;
    bit sink_idle_en = 1'b1;
    int stall_left = 0;

    head_pose_from_face_keypoints_core u_top (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #(12 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arc_vector(inout longint x, input longint y);
        longint z;
        longint xs, ys;
        longint tab[24];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
        z = 0;
        for (int i = 0; i < NSTG; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_out_unit(longint q);
        int s;
        s = QFRAC - AFB;
        return asr(q + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic pose_t predict_pose(longint nx, longint ny, longint lx, longint ly,
                                           longint rx, longint ry);
        pose_t p;
        longint ddx, ddy, x, roll, d2, yaw, pitch;
        logic [63:0] prod;
        p = '0;
        if (!(nx > 0 && ny > 0 && lx > 0 && ly > 0 && rx > 0 && ry > 0 &&
              (lx != rx || ly != ry)))
            return p;
        ddx = rx - lx;
        ddy = ry - ly;
        if (ddx < 0) begin
            ddx = -ddx; ddy = -ddy;
        end
        x = ddx * 65536;
        roll = sat(arc_vector(x, ddy * 65536), 90 * 65536);
        prod = 64'(x) * 64'd163008219 + (64'd1 << 26);
        d2 = longint'(prod >> 27);
        x = d2;
        yaw = arc_vector(x, (2 * nx - lx - rx) * 65536);
        x = d2;
        pitch = arc_vector(x, (2 * ny - ly - ry) * 65536);
        p.ok = 1'b1;
        p.yaw = OUT_W'(sat(to_out_unit(yaw), yaw_lim));
        p.pitch = OUT_W'(sat(to_out_unit(pitch), pitch_lim));
        p.roll = OUT_W'(to_out_unit(roll));
        return p;
    endfunction

    task automatic send_face(int nx, int ny, int lx, int ly, int rx, int ry);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        nose_x <= CB'(nx); nose_y <= CB'(ny);
        left_eye_x <= CB'(lx); left_eye_y <= CB'(ly);
        right_eye_x <= CB'(rx); right_eye_y <= CB'(ry);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_poses.push_back(predict_pose(longint'(CB'(nx) ^ 12'h800) - 2048,
                                             longint'(CB'(ny) ^ 12'h800) - 2048,
                                             longint'(CB'(lx) ^ 12'h800) - 2048,
                                             longint'(CB'(ly) ^ 12'h800) - 2048,
                                             longint'(CB'(rx) ^ 12'h800) - 2048,
                                             longint'(CB'(ry) ^ 12'h800) - 2048));
        @(negedge clk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_poses.size() != 0 && guard < 200000) begin
            @(negedge clk);
            guard++;
        end
        repeat (2 * NSTG + 10) @(negedge clk);
    endtask

    task automatic write_limit(logic idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= LIMIT_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_YAW_LIMIT) yaw_lim = value;
        else pitch_lim = value;
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0 || !sink_idle_en) begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk) begin
        pose_t exp_p;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                exp_p = pending_poses.pop_front();
                if (pose_valid !== exp_p.ok || yaw_angle !== exp_p.yaw ||
                    pitch_angle !== exp_p.pitch || roll_angle !== exp_p.roll) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0b %0d %0d %0d got %0b %0d %0d %0d",
                                 exp_p.ok, $signed(exp_p.yaw), $signed(exp_p.pitch),
                                 $signed(exp_p.roll), pose_valid, yaw_angle,
                                 pitch_angle, roll_angle);
                end
            end
        end
    end

    task automatic test_directed;
        send_face(100, 100, 80, 90, 120, 90);
        send_face(2047, 2047, 1, 1, 2047, 2047);
        send_face(1, 1, 2047, 2047, 1, 1);
        send_face(2047, 1, 1000, 1000, 1001, 1000);
        send_face(1, 2047, 1000, 1000, 1000, 1001);
        send_face(500, 500, 400, 100, 400, 900);
        send_face(500, 500, 400, 900, 400, 100);
        send_face(300, 300, 200, 200, 200, 200);
        send_face(0, 300, 200, 200, 400, 200);
        send_face(300, -1, 200, 200, 400, 200);
        send_face(300, 300, -2048, 200, 400, 200);
        send_face(300, 300, 200, 0, 400, 200);
        send_face(300, 300, 200, 200, -5, 200);
        send_face(300, 300, 200, 200, 400, -2048);
        send_face(-2048, -2048, -2048, -2048, -2048, -2048);
        send_face(1500, 300, 400, 100, 100, 500);
        send_face(200, 1900, 800, 800, 820, 700);
        send_face(1, 1, 1, 1, 2, 2);
        drain();
    endtask

    task automatic random_faces(int n);
        int lx, ly, rx, ry;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_face($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                lx = $urandom_range(1, 2047);
                ly = $urandom_range(1, 2047);
                if ($urandom_range(0, 1)) begin
                    rx = $urandom_range(1, 2047);
                    ry = $urandom_range(1, 2047);
                end else begin
                    rx = (lx + $urandom_range(0, 200) > 2047) ? 2047 : lx + $urandom_range(0, 200);
                    ry = (ly > 50) ? ly - 50 + $urandom_range(0, 100) : ly;
                end
                send_face($urandom_range(1, 2047), $urandom_range(1, 2047), lx, ly, rx, ry);
            end
        end
        drain();
    endtask

    task automatic test_limits;
        write_limit(REG_YAW_LIMIT, 0);
        write_limit(REG_PITCH_LIMIT, 5760);
        random_faces(100);
        write_limit(REG_YAW_LIMIT, 8191);
        write_limit(REG_PITCH_LIMIT, 0);
        random_faces(100);
        write_limit(REG_YAW_LIMIT, 1000);
        write_limit(REG_PITCH_LIMIT, 700);
        random_faces(100);
    endtask

    task automatic test_random_back_to_back;
        write_limit(REG_YAW_LIMIT, 3840);
        write_limit(REG_PITCH_LIMIT, 2560);
        random_faces(150);
        quiet = 1'b1;
        sink_idle_en = 1'b0;
        random_faces(80);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_limits();
        test_random_back_to_back();
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/hpfk_pkg.sv
hw/rtl/hpfk_cordic_cell.sv
hw/rtl/hpfk_scale.sv
hw/rtl/head_pose_from_face_keypoints_core.sv
sim/tb_head_pose_from_face_keypoints_core.sv
